// File: src/bsds_pkg.sv
// Shared types and constants of the box-sum direction select block.
package bsds_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DIFF_W    = 16;
    localparam int CAND_W    = 16;
    localparam int ROW_W     = 12;
    localparam int OUT_COL_W = 12;
    localparam int OFS_W     = 3;
    localparam int ROW_LIMIT = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [OFS_W-1:0] m_hi;
        logic [OFS_W-1:0] n_hi;
        logic             last_row;
        logic             last_col;
        logic             emit;
    } job_t;

endpackage

// File: src/box_sum_direction_select.sv
// Top level of the box-sum direction select block: counters, configuration and wiring.
//
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    gradient_diff, cand_horizontal, cand_vertical
// m_       out        m_valid/m_ready    out_row, out_col, merged_value, took_horizontal,
//                                        last_of_run
// cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// One pixel is taken per cycle while each pixel yields at most one result and the output does
// not stall; a pixel on the last row or last column holds the input until its extra results
// are flushed.
// A result passes through the column-store stage, the sequencer registers and the output register.
// Reset clears the counters and control; the memories need no clearing.
// A stalled output holds the sequencer, which then holds the memory stage and the input.
module box_sum_direction_select import bsds_pkg::*; #(
    parameter int MAX_WIDTH   = 4096,
    parameter int WINDOW_SIZE = 5,
    parameter int PIXEL_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [DIFF_W-1:0] s_gradient_diff,
    input  logic [CAND_W-1:0]     s_cand_horizontal,
    input  logic [CAND_W-1:0]     s_cand_vertical,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_out_row,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic [CAND_W-1:0]     m_merged_value,
    output logic                  m_took_horizontal,
    output logic                  m_last_of_run
);

    localparam int HALF      = WINDOW_SIZE / 2;
    localparam int DIFF_ROWS = 2 * HALF + 1;
    localparam int CAND_ROWS = HALF + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int DSLOT_W   = $clog2(DIFF_ROWS);
    localparam int CSLOT_W   = $clog2(CAND_ROWS);
    localparam int P_W       = DIFF_W + $clog2(DIFF_ROWS);

    logic [CFG_W-1:0]   frame_width_reg, frame_height_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [DSLOT_W-1:0] dslot_reg, dslot_next;
    logic [CSLOT_W-1:0] cslot_reg, cslot_next;

    logic [WCNT_W-1:0]  w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic               restart, accept;
    logic [ROW_W-1:0]   r_use;
    logic [COL_W-1:0]   c_use;
    logic [DSLOT_W-1:0] ds_use;
    logic [CSLOT_W-1:0] cs_use;
    job_t               job;

    logic                            rec_valid, rec_take;
    logic [HALF:0][P_W-1:0]          rec_p;
    logic [HALF:0][2*PIXEL_BITS-1:0] rec_cand;
    logic [COL_W-1:0]                rec_col;
    job_t                            rec_job;

    assign accept = s_valid && s_ready;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WCNT_W'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (int'(frame_height_reg) > ROW_LIMIT) begin
            h_eff = CFG_W'(ROW_LIMIT);
        end else begin
            h_eff = frame_height_reg;
        end
    end

    always_comb begin
        logic oor;
        oor    = (int'(row_reg) >= int'(h_eff)) || (int'(col_reg) >= int'(w_eff));
        r_use  = oor ? '0 : row_reg;
        c_use  = oor ? '0 : col_reg;
        ds_use = oor ? '0 : dslot_reg;
        cs_use = oor ? '0 : cslot_reg;

        job.row      = r_use;
        job.last_row = int'(r_use) == int'(h_eff) - 1;
        job.last_col = int'(c_use) == int'(w_eff) - 1;
        job.m_hi     = (int'(r_use) >= HALF) ? OFS_W'(HALF) : OFS_W'(r_use);
        job.n_hi     = (int'(c_use) >= HALF) ? OFS_W'(HALF) : OFS_W'(c_use);
        job.emit     = (job.last_row || int'(r_use) >= HALF)
                    && (job.last_col || int'(c_use) >= HALF);

        row_next   = row_reg;
        col_next   = col_reg;
        dslot_next = dslot_reg;
        cslot_next = cslot_reg;
        if (restart) begin
            row_next   = '0;
            col_next   = '0;
            dslot_next = '0;
            cslot_next = '0;
        end else if (accept) begin
            if (int'(c_use) + 1 >= int'(w_eff)) begin
                col_next = '0;
                if (int'(r_use) + 1 >= int'(h_eff)) begin
                    row_next   = '0;
                    dslot_next = '0;
                    cslot_next = '0;
                end else begin
                    row_next   = r_use + 1'b1;
                    dslot_next = (int'(ds_use) == DIFF_ROWS - 1) ? '0 : ds_use + 1'b1;
                    cslot_next = (int'(cs_use) == CAND_ROWS - 1) ? '0 : cs_use + 1'b1;
                end
            end else begin
                col_next   = c_use + 1'b1;
                row_next   = r_use;
                dslot_next = ds_use;
                cslot_next = cs_use;
            end
        end
    end

    always_comb begin
        restart = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  restart = 1'b1;
                REG_FRAME_HEIGHT: restart = 1'b1;
                default:          restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(4096);
            frame_height_reg <= CFG_W'(4096);
            row_reg          <= '0;
            col_reg          <= '0;
            dslot_reg        <= '0;
            cslot_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            row_reg   <= row_next;
            col_reg   <= col_next;
            dslot_reg <= dslot_next;
            cslot_reg <= cslot_next;
        end
    end

    bsds_col_store #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WINDOW_SIZE (WINDOW_SIZE),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_col_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_ready),
        .in_col    (c_use),
        .in_dslot  (ds_use),
        .in_cslot  (cs_use),
        .in_diff   (s_gradient_diff),
        .in_cand_h (s_cand_horizontal[PIXEL_BITS-1:0]),
        .in_cand_v (s_cand_vertical[PIXEL_BITS-1:0]),
        .in_job    (job),
        .rec_valid (rec_valid),
        .rec_take  (rec_take),
        .rec_p     (rec_p),
        .rec_cand  (rec_cand),
        .rec_col   (rec_col),
        .rec_job   (rec_job)
    );

    bsds_window_seq #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WINDOW_SIZE (WINDOW_SIZE),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_window_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .rec_valid         (rec_valid),
        .rec_take          (rec_take),
        .rec_p             (rec_p),
        .rec_cand          (rec_cand),
        .rec_col           (rec_col),
        .rec_job           (rec_job),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_row         (m_out_row),
        .m_out_col         (m_out_col),
        .m_merged_value    (m_merged_value),
        .m_took_horizontal (m_took_horizontal),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

// File: src/bsds_col_store.sv
// Column memories with read-modify-write stage that builds one column record per pixel.
module bsds_col_store import bsds_pkg::*; #(
    parameter int MAX_WIDTH   = 4096,
    parameter int WINDOW_SIZE = 5,
    parameter int PIXEL_BITS  = 16,
    localparam int HALF       = WINDOW_SIZE / 2,
    localparam int DIFF_ROWS  = 2 * HALF + 1,
    localparam int CAND_ROWS  = HALF + 1,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int DSLOT_W    = $clog2(DIFF_ROWS),
    localparam int CSLOT_W    = $clog2(CAND_ROWS),
    localparam int P_W        = DIFF_W + $clog2(DIFF_ROWS)
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [COL_W-1:0]                       in_col,
    input  logic [DSLOT_W-1:0]                     in_dslot,
    input  logic [CSLOT_W-1:0]                     in_cslot,
    input  logic signed [DIFF_W-1:0]               in_diff,
    input  logic [PIXEL_BITS-1:0]                  in_cand_h,
    input  logic [PIXEL_BITS-1:0]                  in_cand_v,
    input  job_t                                   in_job,
    output logic                                   rec_valid,
    input  logic                                   rec_take,
    output logic [HALF:0][P_W-1:0]                 rec_p,
    output logic [HALF:0][2*PIXEL_BITS-1:0]        rec_cand,
    output logic [COL_W-1:0]                       rec_col,
    output job_t                                   rec_job
);

    logic [DIFF_ROWS-1:0][DIFF_W-1:0]       diff_mem [MAX_WIDTH];
    logic [CAND_ROWS-1:0][2*PIXEL_BITS-1:0] cand_mem [MAX_WIDTH];

    logic [DIFF_ROWS-1:0][DIFF_W-1:0]       diff_rd_reg, diff_fwd_reg, diff_word, diff_wr;
    logic [CAND_ROWS-1:0][2*PIXEL_BITS-1:0] cand_rd_reg, cand_fwd_reg, cand_word, cand_wr;
    logic                                   fwd_reg;
    logic                                   st_valid_reg;
    logic [COL_W-1:0]                       st_col_reg;
    logic [DSLOT_W-1:0]                     st_dslot_reg;
    logic [CSLOT_W-1:0]                     st_cslot_reg;
    logic signed [DIFF_W-1:0]               st_diff_reg;
    logic [PIXEL_BITS-1:0]                  st_ch_reg;
    logic [PIXEL_BITS-1:0]                  st_cv_reg;
    job_t                                   st_job_reg;
    logic                                   wr_en;
    logic signed [P_W-1:0]                  psum [DIFF_ROWS];

    assign wr_en     = st_valid_reg && rec_take;
    assign in_ready  = !st_valid_reg || rec_take;
    assign rec_valid = st_valid_reg;
    assign rec_col   = st_col_reg;
    assign rec_job   = st_job_reg;

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            diff_rd_reg <= diff_mem[in_col];
            cand_rd_reg <= cand_mem[in_col];
            fwd_reg     <= wr_en && (in_col == st_col_reg);
        end
        if (wr_en) begin
            diff_mem[st_col_reg] <= diff_wr;
            cand_mem[st_col_reg] <= cand_wr;
            diff_fwd_reg         <= diff_wr;
            cand_fwd_reg         <= cand_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (in_valid) begin
            st_valid_reg <= 1'b1;
        end else if (rec_take) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            st_col_reg   <= in_col;
            st_dslot_reg <= in_dslot;
            st_cslot_reg <= in_cslot;
            st_diff_reg  <= in_diff;
            st_ch_reg    <= in_cand_h;
            st_cv_reg    <= in_cand_v;
            st_job_reg   <= in_job;
        end
    end

    always_comb begin
        logic signed [P_W-1:0] acc;
        int                    s;
        logic [DSLOT_W-1:0]    di;
        logic [CSLOT_W-1:0]    ci;
        diff_word = fwd_reg ? diff_fwd_reg : diff_rd_reg;
        cand_word = fwd_reg ? cand_fwd_reg : cand_rd_reg;
        diff_wr   = diff_word;
        diff_wr[st_dslot_reg] = st_diff_reg;
        cand_wr   = cand_word;
        cand_wr[st_cslot_reg] = {st_cv_reg, st_ch_reg};
        acc = '0;
        for (int i = 0; i < DIFF_ROWS; i++) begin
            s = int'(st_dslot_reg) - i;
            if (s < 0) begin
                s = s + DIFF_ROWS;
            end
            di = DSLOT_W'(s);
            if (i <= int'(st_job_reg.row)) begin
                acc = acc + P_W'($signed(diff_wr[di]));
            end
            psum[i] = acc;
        end
        for (int m = 0; m <= HALF; m++) begin
            rec_p[m] = psum[m + HALF];
            s = int'(st_cslot_reg) - m;
            if (s < 0) begin
                s = s + CAND_ROWS;
            end
            ci = CSLOT_W'(s);
            rec_cand[m] = cand_wr[ci];
        end
    end

endmodule

// File: src/bsds_window_seq.sv
// Column record shift line, result sequencer and output register.
module bsds_window_seq import bsds_pkg::*; #(
    parameter int MAX_WIDTH   = 4096,
    parameter int WINDOW_SIZE = 5,
    parameter int PIXEL_BITS  = 16,
    localparam int HALF       = WINDOW_SIZE / 2,
    localparam int LINE_LEN   = 2 * HALF + 1,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int P_W        = DIFF_W + $clog2(LINE_LEN),
    localparam int SUM_W      = P_W + $clog2(LINE_LEN),
    localparam int MIDX_W     = $clog2(HALF + 1),
    localparam int NIDX_W     = $clog2(LINE_LEN)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rec_valid,
    output logic                            rec_take,
    input  logic [HALF:0][P_W-1:0]          rec_p,
    input  logic [HALF:0][2*PIXEL_BITS-1:0] rec_cand,
    input  logic [COL_W-1:0]                rec_col,
    input  job_t                            rec_job,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ROW_W-1:0]                m_out_row,
    output logic [OUT_COL_W-1:0]            m_out_col,
    output logic [CAND_W-1:0]               m_merged_value,
    output logic                            m_took_horizontal,
    output logic                            m_last_of_run
);

    logic [HALF:0][P_W-1:0]          line_p_reg    [LINE_LEN];
    logic [HALF:0][2*PIXEL_BITS-1:0] line_cand_reg [LINE_LEN];
    logic                            job_active_reg;
    logic [OFS_W-1:0]                m_cur_reg, m_lo_reg, n_cur_reg, n_lo_reg, n_hi_reg;
    logic [ROW_W-1:0]                row_reg;
    logic [COL_W-1:0]                col_reg;
    logic                            m_valid_reg;
    logic [ROW_W-1:0]                out_row_reg;
    logic [OUT_COL_W-1:0]            out_col_reg;
    logic [CAND_W-1:0]               merged_reg;
    logic                            took_h_reg;
    logic                            last_reg;

    logic                            out_free, beat, last_beat;
    logic signed [SUM_W-1:0]         sum;
    logic [2*PIXEL_BITS-1:0]         cand_sel;
    logic                            neg;

    assign out_free  = !m_valid_reg || m_ready;
    assign beat      = job_active_reg && out_free;
    assign last_beat = (m_cur_reg == m_lo_reg) && (n_cur_reg == n_lo_reg);
    assign rec_take  = rec_valid && (!job_active_reg || (beat && last_beat));

    always_comb begin
        int n;
        n   = int'(n_cur_reg);
        sum = '0;
        for (int q = 0; q < LINE_LEN; q++) begin
            if ((q + HALF >= n) && (q <= n + HALF) && (q <= int'(col_reg))) begin
                sum = sum + SUM_W'($signed(line_p_reg[q][MIDX_W'(m_cur_reg)]));
            end
        end
        neg      = sum < 0;
        cand_sel = line_cand_reg[NIDX_W'(n_cur_reg)][MIDX_W'(m_cur_reg)];
    end

    always_ff @(posedge aclk) begin
        if (rec_take) begin
            line_p_reg[0]    <= rec_p;
            line_cand_reg[0] <= rec_cand;
            for (int q = 1; q < LINE_LEN; q++) begin
                line_p_reg[q]    <= line_p_reg[q-1];
                line_cand_reg[q] <= line_cand_reg[q-1];
            end
            m_cur_reg <= rec_job.m_hi;
            m_lo_reg  <= rec_job.last_row ? '0 : rec_job.m_hi;
            n_cur_reg <= rec_job.n_hi;
            n_hi_reg  <= rec_job.n_hi;
            n_lo_reg  <= rec_job.last_col ? '0 : rec_job.n_hi;
            row_reg   <= rec_job.row;
            col_reg   <= rec_col;
        end else if (beat && !last_beat) begin
            if (n_cur_reg == n_lo_reg) begin
                m_cur_reg <= m_cur_reg - 1'b1;
                n_cur_reg <= n_hi_reg;
            end else begin
                n_cur_reg <= n_cur_reg - 1'b1;
            end
        end
        if (beat) begin
            out_row_reg <= row_reg - ROW_W'(m_cur_reg);
            out_col_reg <= OUT_COL_W'(col_reg - COL_W'(n_cur_reg));
            merged_reg  <= CAND_W'(neg ? cand_sel[PIXEL_BITS-1:0]
                                       : cand_sel[2*PIXEL_BITS-1:PIXEL_BITS]);
            took_h_reg  <= neg;
            last_reg    <= last_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_active_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (rec_take) begin
                job_active_reg <= rec_job.emit;
            end else if (beat && last_beat) begin
                job_active_reg <= 1'b0;
            end
            if (beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_row         = out_row_reg;
    assign m_out_col         = out_col_reg;
    assign m_merged_value    = merged_reg;
    assign m_took_horizontal = took_h_reg;
    assign m_last_of_run     = last_reg;

endmodule

// File: tb/box_sum_direction_select_tb.sv
// Self-checking testbench for box_sum_direction_select, with its own window-sum predictor.
`timescale 1ns / 1ps

module box_sum_direction_select_tb;
    import bsds_pkg::*;

    localparam int MAX_W = 4096;
    localparam int HALF = 2;
    localparam int KEY_STRIDE = 8192;
    localparam int RANDOM_ITEMS = 40;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [CAND_W-1:0]    value;
        logic                 horiz;
        logic                 last;
    } decision_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic signed [DIFF_W-1:0] s_gradient_diff;
    logic [CAND_W-1:0] s_cand_horizontal;
    logic [CAND_W-1:0] s_cand_vertical;
    logic m_valid;
    logic m_ready;
    logic [ROW_W-1:0] m_out_row;
    logic [OUT_COL_W-1:0] m_out_col;
    logic [CAND_W-1:0] m_merged_value;
    logic m_took_horizontal;
    logic m_last_of_run;

    decision_t pending_decisions[$];
    int diff_mem[int];
    int horiz_mem[int];
    int vert_mem[int];
    int width_reg;
    int height_reg;
    int row_pos;
    int col_pos;
    int mismatches;
    bit hold_request;
    bit valid_high;
    int burst_left;
    bit gaps_on;

    box_sum_direction_select dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_gradient_diff(s_gradient_diff),
        .s_cand_horizontal(s_cand_horizontal),
        .s_cand_vertical(s_cand_vertical),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_row(m_out_row),
        .m_out_col(m_out_col),
        .m_merged_value(m_merged_value),
        .m_took_horizontal(m_took_horizontal),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int clipped_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return width_reg;
    endfunction

    function automatic int clipped_height();
        if (height_reg == 0) return 1;
        if (height_reg > ROW_LIMIT) return ROW_LIMIT;
        return height_reg;
    endfunction

    function automatic int box_sum(int pr, int pc, int w, int h);
        int sum;
        sum = 0;
        for (int r = (pr >= HALF ? pr - HALF : 0); r <= (pr + HALF < h ? pr + HALF : h - 1); r++)
            for (int c = (pc >= HALF ? pc - HALF : 0);
                 c <= (pc + HALF < w ? pc + HALF : w - 1); c++)
                sum += diff_mem[r * KEY_STRIDE + c];
        return sum;
    endfunction

    task automatic predict_decisions(logic signed [DIFF_W-1:0] gd, logic [CAND_W-1:0] ch,
                                     logic [CAND_W-1:0] cv);
        int w, h, r, c, rlo, rhi, clo, chi, key;
        decision_t d;
        w = clipped_width();
        h = clipped_height();
        r = row_pos;
        c = col_pos;
        if (r >= h || c >= w) begin
            r = 0;
            c = 0;
        end
        if (r == 0 && c == 0) begin
            diff_mem.delete();
            horiz_mem.delete();
            vert_mem.delete();
        end
        key = r * KEY_STRIDE + c;
        diff_mem[key] = int'(gd);
        horiz_mem[key] = ch;
        vert_mem[key] = cv;
        rlo = r >= HALF ? r - HALF : 0;
        rhi = (r == h - 1) ? r : rlo;
        clo = c >= HALF ? c - HALF : 0;
        chi = (c == w - 1) ? c : clo;
        if ((r == h - 1 || r >= HALF) && (c == w - 1 || c >= HALF)) begin
            for (int pr = rlo; pr <= rhi; pr++) begin
                for (int pc = clo; pc <= chi; pc++) begin
                    d.row = pr[ROW_W-1:0];
                    d.col = pc[OUT_COL_W-1:0];
                    d.horiz = box_sum(pr, pc, w, h) < 0;
                    d.value = d.horiz ? horiz_mem[pr * KEY_STRIDE + pc]
                                      : vert_mem[pr * KEY_STRIDE + pc];
                    d.last = (pr == rhi && pc == chi);
                    pending_decisions.push_back(d);
                end
            end
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge aclk) begin
        decision_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result row %0d col %0d", m_out_row, m_out_col);
            end else begin
                e = pending_decisions.pop_front();
                if (m_out_row !== e.row || m_out_col !== e.col || m_merged_value !== e.value
                    || m_took_horizontal !== e.horiz || m_last_of_run !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected row %0d col %0d value %h horiz %b last %b",
                                 e.row, e.col, e.value, e.horiz, e.last);
                        $display("          got row %0d col %0d value %h horiz %b last %b",
                                 m_out_row, m_out_col, m_merged_value, m_took_horizontal,
                                 m_last_of_run);
                    end
                end
            end
        end
    end

    // The receiver alternates stall-free and random-stall stretches, or holds on request.
    initial begin
        int stretch;
        int mode;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 400; i++) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stretch = $urandom_range(5, 60);
                mode = $urandom_range(0, 2);
                for (int i = 0; i < stretch && !hold_request; i++) begin
                    m_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode + 1) != 0);
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic send_pixel(logic signed [DIFF_W-1:0] gd, logic [CAND_W-1:0] ch,
                              logic [CAND_W-1:0] cv);
        int gap;
        s_valid <= 1'b1;
        s_gradient_diff <= gd;
        s_cand_horizontal <= ch;
        s_cand_vertical <= cv;
        valid_high = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_decisions(gd, ch, cv);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_random_pixel();
        send_pixel(DIFF_W'($urandom), CAND_W'($urandom), CAND_W'($urandom));
    endtask

    task automatic drain();
        int waited;
        if (valid_high) begin
            s_valid <= 1'b0;
            valid_high = 1'b0;
        end
        waited = 0;
        while (pending_decisions.size() != 0) begin
            @(posedge aclk);
            waited++;
            if (waited > 200000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
            if (idx == REG_FRAME_WIDTH) width_reg = value & 13'h1FFF;
            else height_reg = value & 13'h1FFF;
            row_pos = 0;
            col_pos = 0;
        end
    endtask

    task automatic set_frame(int w, int h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    task automatic send_frames(int count);
        for (int i = 0; i < count; i++) send_random_pixel();
    endtask

    task automatic test_field_extremes();
        set_frame(5, 5);
        send_pixel(16'sh8000, 16'h0000, 16'hFFFF);
        send_pixel(16'sh7FFF, 16'hFFFF, 16'h0000);
        send_pixel(16'sh0000, 16'hAAAA, 16'h5555);
        send_pixel(-16'sd1, 16'h5555, 16'hAAAA);
        send_pixel(16'sh0001, 16'h1234, 16'h4321);
        for (int i = 0; i < 20; i++)
            send_pixel((i % 2) ? 16'sh8000 : 16'sh7FFF, 16'hFFFF, 16'h0000);
    endtask

    task automatic test_degenerate_sizes();
        set_frame(1, 1);
        send_frames(3);
        set_frame(0, 0);
        send_frames(3);
        set_frame(3, 1);
        send_frames(6);
        set_frame(1, 4);
        send_frames(8);
        set_frame(2, 2);
        send_frames(4);
    endtask

    task automatic test_widest_row();
        set_frame(8191, 1);
        send_frames(10);
        set_frame(MAX_W, 2);
        send_frames(20);
    endtask

    task automatic test_tallest_column();
        set_frame(1, 8191);
        send_frames(12);
        set_frame(3, ROW_LIMIT);
        send_frames(12);
    endtask

    task automatic test_spare_index();
        set_frame(4, 4);
        send_frames(6);
        write_register(REG_SPARE_A, 13'h1FFF);
        write_register(REG_SPARE_B, 0);
        send_frames(10);
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            gaps_on = $urandom_range(0, 3) != 0;
            set_frame(w, h);
            n = $urandom_range(1, 2 * w * h);
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            send_frames(n);
            sent += n;
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_frame(8, 6);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        send_frames(48);
        gaps_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_gradient_diff = '0;
        s_cand_horizontal = '0;
        s_cand_vertical = '0;
        mismatches = 0;
        hold_request = 1'b0;
        valid_high = 1'b0;
        burst_left = 0;
        gaps_on = 1'b1;
        width_reg = 4096;
        height_reg = 4096;
        row_pos = 0;
        col_pos = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_degenerate_sizes();
        test_widest_row();
        test_tallest_column();
        test_spare_index();
        test_random_frames();
        test_output_backpressure();
        drain();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
